[rtl/core/pc_pkg.sv]
// shared constants, codes and control/status types for the correlation block
`default_nettype none

package pc_pkg;

    localparam int SAMPLE_W  = 25;
    localparam int CNT_W     = 13;
    localparam int SUM_W     = 37;
    localparam int SQ_W      = 62;
    localparam int OPW       = 75;
    localparam int PRODW     = 2 * OPW;
    localparam int DIV_SHIFT = 30;
    localparam int REMW      = PRODW + DIV_SHIFT;
    localparam int QW        = DIV_SHIFT + 1;
    localparam int ROOT_W    = 16;
    localparam int CORR_W    = 16;
    localparam int ROOT_STEPS = (QW + 1) / 2;
    localparam int STEP_W    = $clog2(OPW);

    localparam int MAX_ITEMS_DEF   = 4096;
    localparam int SAMPLE_BITS_DEF = 25;

    // which product the accumulate cycle adds
    localparam logic [1:0] MAC_XX = 2'd0;
    localparam logic [1:0] MAC_YY = 2'd1;
    localparam logic [1:0] MAC_XY = 2'd2;

    // wide multiply operations, run in this order
    localparam logic [2:0] OP_N_SXX   = 3'd0;
    localparam logic [2:0] OP_SX_SX   = 3'd1;
    localparam logic [2:0] OP_N_SYY   = 3'd2;
    localparam logic [2:0] OP_SY_SY   = 3'd3;
    localparam logic [2:0] OP_N_SXY   = 3'd4;
    localparam logic [2:0] OP_SX_SY   = 3'd5;
    localparam logic [2:0] OP_L_R     = 3'd6;
    localparam logic [2:0] OP_NUM_NUM = 3'd7;

    typedef struct packed {
        logic       accept;
        logic       mac_en;
        logic [1:0] mac_sel;
        logic       mul_load;
        logic       mul_step;
        logic       mul_save;
        logic [2:0] mul_op;
        logic       div_load;
        logic       div_step;
        logic       sqrt_load;
        logic       sqrt_step;
        logic       out_load;
    } pc_cmd_t;

    typedef struct packed {
        logic last;
        logic degen;
    } pc_sts_t;

endpackage

`default_nettype wire

[rtl/core/pearson_correlation.sv]
// top level of the paired-sample correlation block
//
//  channel  direction  handshake            payload
//  in       sink       in_valid / in_ready  x_value, y_value, last_pair
//  out      source     out_valid/out_ready  correlation, degenerate, overflowed, pair_count
//
// a pair is taken in one state, then x*x, y*y and x*y run in turn on the single 25x25
// multiplier. a last pair then runs eight wide shift-add multiplies, the divide and
// the root (fewer when degenerate). reset is asynchronous and clears all sums. a
// waiting result is held in the output register while new pairs are taken; a finished
// set waits until that register is free.
`default_nettype none

module pearson_correlation
    import pc_pkg::*;
#(
    parameter int MAX_ITEMS   = MAX_ITEMS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [SAMPLE_W-1:0] x_value,
    input  wire logic [SAMPLE_W-1:0] y_value,
    input  wire logic                last_pair,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic signed [CORR_W-1:0] correlation,
    output logic                     degenerate,
    output logic                     overflowed,
    output logic [CNT_W-1:0]         pair_count
);

    pc_cmd_t cmd;
    pc_sts_t sts;

    pc_control u_control (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    pc_datapath #(
        .MAX_ITEMS   (MAX_ITEMS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .x_value     (x_value),
        .y_value     (y_value),
        .last_pair   (last_pair),
        .cmd         (cmd),
        .sts         (sts),
        .correlation (correlation),
        .degenerate  (degenerate),
        .overflowed  (overflowed),
        .pair_count  (pair_count)
    );

endmodule

`default_nettype wire

[rtl/core/pc_datapath.sv]
// sums, wide shift-add multiplier, restoring divider, square root and result registers
`default_nettype none

module pc_datapath
    import pc_pkg::*;
#(
    parameter int MAX_ITEMS   = MAX_ITEMS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [SAMPLE_W-1:0] x_value,
    input  wire logic [SAMPLE_W-1:0] y_value,
    input  wire logic                last_pair,
    input  wire pc_cmd_t             cmd,
    output pc_sts_t                  sts,
    output logic signed [CORR_W-1:0] correlation,
    output logic                     degenerate,
    output logic                     overflowed,
    output logic [CNT_W-1:0]         pair_count
);

    localparam logic [SAMPLE_W-1:0] SMASK = {SAMPLE_W{1'b1}} >> (SAMPLE_W - SAMPLE_BITS);
    localparam logic [CNT_W-1:0]    LIMIT = CNT_W'(MAX_ITEMS);

    // set state
    logic [CNT_W-1:0] cnt_reg;
    logic [SUM_W-1:0] sx_reg, sy_reg;
    logic [SQ_W-1:0]  sxx_reg, syy_reg, sxy_reg;
    logic             drop_reg, degen_reg, last_reg, ok_reg;

    // working registers
    logic [SAMPLE_W-1:0] x_reg, y_reg;
    logic [PRODW-1:0]    mc_reg, prod_reg, dvs_reg;
    logic [OPW-1:0]      mp_reg, p1_reg, left_reg, right_reg, num_reg;
    logic                neg_reg;
    logic [REMW-1:0]     rem_reg, dsh_reg;
    logic [QW-1:0]       quo_reg, sop_reg, res_reg, one_reg;

    logic [SAMPLE_W-1:0]   ma, mb;
    logic [2*SAMPLE_W-1:0] mprod;
    logic [OPW-1:0]        mc_src, mp_src, plo;
    logic [QW-1:0]         trial;
    logic [ROOT_W-1:0]     root;
    logic [CORR_W-1:0]     corr_val;

    always_comb
    begin
        case (cmd.mac_sel)
            MAC_XX:  begin ma = x_reg; mb = x_reg; end
            MAC_YY:  begin ma = y_reg; mb = y_reg; end
            MAC_XY:  begin ma = x_reg; mb = y_reg; end
            default: begin ma = '0;    mb = '0;    end
        endcase
        mprod = ma * mb;
    end

    always_comb
    begin
        case (cmd.mul_op)
            OP_N_SXX:   begin mc_src = OPW'(sxx_reg);  mp_src = OPW'(cnt_reg);   end
            OP_SX_SX:   begin mc_src = OPW'(sx_reg);   mp_src = OPW'(sx_reg);    end
            OP_N_SYY:   begin mc_src = OPW'(syy_reg);  mp_src = OPW'(cnt_reg);   end
            OP_SY_SY:   begin mc_src = OPW'(sy_reg);   mp_src = OPW'(sy_reg);    end
            OP_N_SXY:   begin mc_src = OPW'(sxy_reg);  mp_src = OPW'(cnt_reg);   end
            OP_SX_SY:   begin mc_src = OPW'(sx_reg);   mp_src = OPW'(sy_reg);    end
            OP_L_R:     begin mc_src = left_reg;       mp_src = right_reg;       end
            OP_NUM_NUM: begin mc_src = num_reg;        mp_src = num_reg;         end
            default:    begin mc_src = '0;             mp_src = '0;              end
        endcase
    end

    assign plo   = prod_reg[OPW-1:0];
    assign trial = res_reg + one_reg;
    assign root  = res_reg[ROOT_W-1:0];

    always_comb
    begin
        if (degen_reg)
            corr_val = '0;
        else if (neg_reg)
            corr_val = ~root + 1'b1;
        else if (root[ROOT_W-1])
            corr_val = {1'b0, {(CORR_W-1){1'b1}}};
        else
            corr_val = root;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            sx_reg    <= '0;
            sy_reg    <= '0;
            sxx_reg   <= '0;
            syy_reg   <= '0;
            sxy_reg   <= '0;
            drop_reg  <= 1'b0;
            degen_reg <= 1'b0;
            last_reg  <= 1'b0;
            ok_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                last_reg <= last_pair;
                if (cnt_reg < LIMIT)
                begin
                    ok_reg  <= 1'b1;
                    cnt_reg <= cnt_reg + 1'b1;
                    sx_reg  <= sx_reg + SUM_W'(x_value & SMASK);
                    sy_reg  <= sy_reg + SUM_W'(y_value & SMASK);
                end
                else
                begin
                    ok_reg   <= 1'b0;
                    drop_reg <= 1'b1;
                end
            end
            if (cmd.mac_en && ok_reg)
            begin
                case (cmd.mac_sel)
                    MAC_XX:  sxx_reg <= sxx_reg + SQ_W'(mprod);
                    MAC_YY:  syy_reg <= syy_reg + SQ_W'(mprod);
                    MAC_XY:  sxy_reg <= sxy_reg + SQ_W'(mprod);
                    default: ;
                endcase
            end
            if (cmd.mul_save && (cmd.mul_op == OP_SX_SX || cmd.mul_op == OP_SY_SY))
            begin
                if (p1_reg <= plo)
                    degen_reg <= 1'b1;
            end
            if (cmd.out_load)
            begin
                cnt_reg   <= '0;
                sx_reg    <= '0;
                sy_reg    <= '0;
                sxx_reg   <= '0;
                syy_reg   <= '0;
                sxy_reg   <= '0;
                drop_reg  <= 1'b0;
                degen_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            x_reg <= x_value & SMASK;
            y_reg <= y_value & SMASK;
        end
        if (cmd.mul_load)
        begin
            mc_reg   <= PRODW'(mc_src);
            mp_reg   <= mp_src;
            prod_reg <= '0;
        end
        else if (cmd.mul_step)
        begin
            if (mp_reg[0])
                prod_reg <= prod_reg + mc_reg;
            mc_reg <= mc_reg << 1;
            mp_reg <= mp_reg >> 1;
        end
        if (cmd.mul_save)
        begin
            case (cmd.mul_op)
                OP_N_SXX, OP_N_SYY, OP_N_SXY: p1_reg <= plo;
                OP_SX_SX:   left_reg  <= p1_reg - plo;
                OP_SY_SY:   right_reg <= p1_reg - plo;
                OP_SX_SY:
                begin
                    neg_reg <= (p1_reg < plo);
                    num_reg <= (p1_reg < plo) ? (plo - p1_reg) : (p1_reg - plo);
                end
                OP_L_R:     dvs_reg <= prod_reg;
                OP_NUM_NUM: rem_reg <= {prod_reg, {DIV_SHIFT{1'b0}}};
                default: ;
            endcase
        end
        // quotient is at most 2^30, so 31 restoring steps cover it
        if (cmd.div_load)
        begin
            dsh_reg <= {dvs_reg, {DIV_SHIFT{1'b0}}};
            quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_reg <= rem_reg - dsh_reg;
                quo_reg <= {quo_reg[QW-2:0], 1'b1};
            end
            else
                quo_reg <= {quo_reg[QW-2:0], 1'b0};
            dsh_reg <= dsh_reg >> 1;
        end
        // digit-by-digit integer root, two radicand bits per step
        if (cmd.sqrt_load)
        begin
            sop_reg <= quo_reg;
            res_reg <= '0;
            one_reg <= {1'b1, {(QW-1){1'b0}}};
        end
        else if (cmd.sqrt_step)
        begin
            if (sop_reg >= trial)
            begin
                sop_reg <= sop_reg - trial;
                res_reg <= (res_reg >> 1) + one_reg;
            end
            else
                res_reg <= res_reg >> 1;
            one_reg <= one_reg >> 2;
        end
        if (cmd.out_load)
        begin
            correlation <= corr_val;
            degenerate  <= degen_reg;
            overflowed  <= drop_reg;
            pair_count  <= cnt_reg;
        end
    end

    assign sts.last  = last_reg;
    assign sts.degen = degen_reg;

endmodule

`default_nettype wire

[rtl/core/pc_control.sv]
// sequencer for accumulation, the wide multiplies, the divide and the root
`default_nettype none

module pc_control
    import pc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  wire logic    out_ready,
    input  wire pc_sts_t sts,
    output pc_cmd_t      cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SQX   = 4'd1;
    localparam logic [3:0] S_SQY   = 4'd2;
    localparam logic [3:0] S_XY    = 4'd3;
    localparam logic [3:0] S_MLOAD = 4'd4;
    localparam logic [3:0] S_MRUN  = 4'd5;
    localparam logic [3:0] S_MSAVE = 4'd6;
    localparam logic [3:0] S_DLOAD = 4'd7;
    localparam logic [3:0] S_DRUN  = 4'd8;
    localparam logic [3:0] S_QLOAD = 4'd9;
    localparam logic [3:0] S_QRUN  = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;

    logic [3:0]        state_reg, state_next;
    logic [2:0]        op_reg, op_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.mul_op     = op_reg;
        in_ready       = 1'b0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_SQX;
                end
            end
            S_SQX:
            begin
                cmd.mac_en  = 1'b1;
                cmd.mac_sel = MAC_XX;
                state_next  = S_SQY;
            end
            S_SQY:
            begin
                cmd.mac_en  = 1'b1;
                cmd.mac_sel = MAC_YY;
                state_next  = S_XY;
            end
            S_XY:
            begin
                cmd.mac_en  = 1'b1;
                cmd.mac_sel = MAC_XY;
                op_next     = OP_N_SXX;
                state_next  = sts.last ? S_MLOAD : S_IDLE;
            end
            S_MLOAD:
            begin
                // both variance terms known here: skip the rest if either is not positive
                if (op_reg == OP_N_SXY && sts.degen)
                    state_next = S_FIN;
                else
                begin
                    cmd.mul_load = 1'b1;
                    step_next    = STEP_W'(OPW - 1);
                    state_next   = S_MRUN;
                end
            end
            S_MRUN:
            begin
                cmd.mul_step = 1'b1;
                if (step_reg == '0)
                    state_next = S_MSAVE;
                else
                    step_next = step_reg - 1'b1;
            end
            S_MSAVE:
            begin
                cmd.mul_save = 1'b1;
                if (op_reg == OP_NUM_NUM)
                    state_next = S_DLOAD;
                else
                begin
                    op_next    = op_reg + 1'b1;
                    state_next = S_MLOAD;
                end
            end
            S_DLOAD:
            begin
                cmd.div_load = 1'b1;
                step_next    = STEP_W'(QW - 1);
                state_next   = S_DRUN;
            end
            S_DRUN:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == '0)
                    state_next = S_QLOAD;
                else
                    step_next = step_reg - 1'b1;
            end
            S_QLOAD:
            begin
                cmd.sqrt_load = 1'b1;
                step_next     = STEP_W'(ROOT_STEPS - 1);
                state_next    = S_QRUN;
            end
            S_QRUN:
            begin
                cmd.sqrt_step = 1'b1;
                if (step_reg == '0)
                    state_next = S_FIN;
                else
                    step_next = step_reg - 1'b1;
            end
            S_FIN:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_N_SXX;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire
